FILE: design/lsal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsal_pkg: shared types and constants of the auto-ranging lux block
// Item formats, state codes, fixed-point coefficients and level tables.
// ----------------------------------------------------------------------------
package lsal_pkg;

   localparam int MUL_A_W   = 64;   // signed multiplicand width
   localparam int MUL_B_W   = 50;   // unsigned multiplier width, one bit per cycle
   localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam logic signed [63:0] COEF_A = 64'sd2839795084;
   localparam logic signed [63:0] COEF_B = -64'sd44354354953705;
   localparam logic signed [63:0] COEF_C = 64'sd1503188281078444;
   localparam logic signed [63:0] COEF_D = 64'sd4304845721;
   localparam logic [17:0]         LUX_MAX = 18'd140000;

   localparam logic [2:0] CSR_GAIN   = 3'd0;
   localparam logic [2:0] CSR_DARK   = 3'd1;
   localparam logic [2:0] CSR_BRIGHT = 3'd2;
   localparam logic [2:0] CSR_SAT    = 3'd3;
   localparam logic [2:0] CSR_WEAK   = 3'd4;

   typedef struct packed {
      logic [15:0] raw_count;
      logic        read_failed;
   } req_type;

   typedef struct packed {
      logic [17:0] lux;
      logic        lux_valid;
      logic        reconfigure;
      logic [2:0]  level;
      logic [9:0]  integration_ms;
      logic        read_error;
   } rsp_type;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_type;

   typedef enum logic [2:0] {PH_X, PH_H3, PH_H2, PH_H1, PH_P, PH_GAIN} phase_type;

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0]        b;
   } mul_req_type;

   // resolution per level, Q32
   function automatic logic [33:0] res_q32(input logic [2:0] lvl);
      logic [33:0] r;
      case (lvl)
         3'd0:    r = 34'd18038863;
         3'd1:    r = 34'd1154487209;
         3'd2:    r = 34'd2308974418;
         3'd3:    r = 34'd4617948837;
         default: r = 34'd9235897673;
      endcase
      return r;
   endfunction

   function automatic logic [9:0] it_ms(input logic [2:0] lvl);
      logic [9:0] t;
      case (lvl)
         3'd0:    t = 10'd800;
         3'd1:    t = 10'd100;
         3'd2:    t = 10'd100;
         3'd3:    t = 10'd50;
         default: t = 10'd25;
      endcase
      return t;
   endfunction

endpackage

FILE: design/lsal_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsal_mul: bit-serial signed by unsigned multiplier
// Consumes one multiplier bit per cycle, shifting the product right.
// ----------------------------------------------------------------------------
module lsal_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lsal_pkg::mul_req_type                mreq,
   output logic                                 done,
   output logic signed [lsal_pkg::MUL_P_W-1:0]  prod
);
   import lsal_pkg::*;

   logic signed [MUL_A_W:0]   hi_ff, hi_in;
   logic [MUL_B_W-1:0]        lo_ff, lo_in;
   logic signed [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic signed [MUL_A_W:0]   sum;

   // partial sum of the high half and the multiplicand
   assign sum = hi_ff + (lo_ff[0] ? {a_ff[MUL_A_W-1], a_ff} : '0);

   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mreq.start) begin
         hi_in   = '0;
         lo_in   = mreq.b;
         a_in    = mreq.a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {sum[MUL_A_W], sum[MUL_A_W:1]};
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

   busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff)) else $error("multiplier done while busy");
   done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done longer than one cycle");
   start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      mreq.start |=> busy_ff) else $error("start did not raise busy");

endmodule

FILE: design/light_sensor_autorange_lux_top.sv
`timescale 1ns / 1ps
// result: a read error or level step is delivered without a multiplier pass; level 0 runs
//   the resolution and gain passes, levels 1 to 4 six passes of the bit-serial multiplier
// throughput: one item at a time, next item taken once the result has been delivered
// reset: synchronous, level 2, cooldown 0, registers to their defaults
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_top: auto-ranging lux conversion
// Level stepping with cooldown, Horner linearisation and gain scaling.
// ----------------------------------------------------------------------------
module light_sensor_autorange_lux_top #(
   parameter int COOLDOWN_SAMPLES = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lsal_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lsal_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   import lsal_pkg::*;

   // configuration registers
   logic [23:0] gain_ff;
   logic [15:0] dark_ff, bright_ff, sat_ff, weak_ff;

   // ranging state
   logic [2:0]  level_ff, level_in;
   logic [1:0]  cool_ff, cool_in;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [MUL_B_W-1:0] x_ff, x_in;
   mul_req_type mreq_ff, mreq_in;
   rsp_type     rsp_ff, rsp_in;
   logic        finish;

   logic        mul_done;
   logic signed [MUL_P_W-1:0] prod;

   logic        req_take;
   logic        up, down, moved;
   logic [2:0]  next_lvl;

   // floored shifts of the product, kept to 64 bits
   logic signed [63:0] sh32, sh40, sh64, p_val;
   logic [88:0]        rsum;
   logic [40:0]        lux_wide;

   lsal_mul u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq_ff),
      .done  (mul_done),
      .prod  (prod)
   );

   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // level step decision: upward test first
   always_comb begin
      up   = 1'b0;
      down = 1'b0;
      case (level_ff)
         3'd0: up = (req_payload.raw_count > sat_ff) || (req_payload.raw_count > weak_ff);
         3'd1: begin
            up   = req_payload.raw_count > sat_ff;
            down = req_payload.raw_count <= dark_ff;
         end
         3'd2, 3'd3: begin
            up   = req_payload.raw_count > bright_ff;
            down = req_payload.raw_count <= dark_ff;
         end
         default: down = req_payload.raw_count <= dark_ff;
      endcase
      moved    = (cool_ff == 2'd0) && (up || down);
      next_lvl = level_ff;
      if (moved) next_lvl = up ? level_ff + 3'd1 : level_ff - 3'd1;
   end

   assign sh32 = prod[95:32];
   assign sh40 = prod[103:40];
   assign sh64 = {{(128 - MUL_P_W){prod[MUL_P_W-1]}}, prod[MUL_P_W-1:64]};
   // round half up of the gain product, Q48 down to integer
   assign rsum     = {1'b0, prod[87:0]} + (89'd1 << 47);
   assign lux_wide = rsum[88:48];
   // corrected value ahead of the gain pass: raw resolution on level 0
   assign p_val = (phase_ff == PH_X) ? {14'd0, prod[MUL_B_W-1:0]} : sh32;

   // datapath and sequencing of the multiplier passes
   always_comb begin
      level_in = level_ff;
      cool_in  = cool_ff;
      phase_in = phase_ff;
      x_in     = x_ff;
      mreq_in  = mreq_ff;
      mreq_in.start = 1'b0;
      rsp_in   = rsp_ff;
      finish   = 1'b0;
      if (req_take) begin
         rsp_in.lux            = '0;
         rsp_in.lux_valid      = 1'b0;
         rsp_in.reconfigure    = 1'b0;
         rsp_in.level          = level_ff;
         rsp_in.integration_ms = it_ms(level_ff);
         rsp_in.read_error     = req_payload.read_failed;
         if (req_payload.read_failed) begin
            finish = 1'b1;
         end else begin
            if (cool_ff != 2'd0) cool_in = cool_ff - 2'd1;
            if (moved) begin
               // step: new level, hold off further steps
               level_in              = next_lvl;
               cool_in               = 2'(COOLDOWN_SAMPLES);
               rsp_in.reconfigure    = 1'b1;
               rsp_in.level          = next_lvl;
               rsp_in.integration_ms = it_ms(next_lvl);
               finish                = 1'b1;
            end else begin
               // first pass: count times resolution
               mreq_in.start = 1'b1;
               mreq_in.a     = {30'd0, res_q32(level_ff)};
               mreq_in.b     = {34'd0, req_payload.raw_count};
               phase_in      = PH_X;
            end
         end
      end else if (state_ff == ST_RUN && mul_done) begin
         case (phase_ff)
            PH_X, PH_P: begin
               if (phase_ff == PH_X) x_in = prod[MUL_B_W-1:0];
               if (phase_ff == PH_X && level_ff != 3'd0) begin
                  mreq_in.start = 1'b1;
                  mreq_in.a     = COEF_A;
                  mreq_in.b     = prod[MUL_B_W-1:0];
                  phase_in      = PH_H3;
               end else if (p_val <= 64'sd0) begin
                  // correction dipped to zero or below
                  rsp_in.lux       = '0;
                  rsp_in.lux_valid = 1'b1;
                  finish           = 1'b1;
               end else begin
                  mreq_in.start = 1'b1;
                  mreq_in.a     = p_val;
                  mreq_in.b     = {26'd0, gain_ff};
                  phase_in      = PH_GAIN;
               end
            end
            PH_H3: begin
               mreq_in.start = 1'b1;
               mreq_in.a     = sh32 + COEF_B;
               mreq_in.b     = x_ff;
               phase_in      = PH_H2;
            end
            PH_H2: begin
               mreq_in.start = 1'b1;
               mreq_in.a     = sh40 + COEF_C;
               mreq_in.b     = x_ff;
               phase_in      = PH_H1;
            end
            PH_H1: begin
               mreq_in.start = 1'b1;
               mreq_in.a     = sh64 + COEF_D;
               mreq_in.b     = x_ff;
               phase_in      = PH_P;
            end
            PH_GAIN: begin
               rsp_in.lux       = (lux_wide > {23'd0, LUX_MAX}) ? LUX_MAX : lux_wide[17:0];
               rsp_in.lux_valid = 1'b1;
               finish           = 1'b1;
            end
            default: finish = 1'b1;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take) state_in = finish ? ST_OUT : ST_RUN;
         ST_RUN:  if (finish) state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rsp_ff  <= rsp_in;
      mreq_ff.a <= mreq_in.a;
      mreq_ff.b <= mreq_in.b;
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_X;
         level_ff      <= 3'd2;
         cool_ff       <= 2'd0;
         mreq_ff.start <= 1'b0;
         gain_ff       <= 24'd65536;
         dark_ff       <= 16'd100;
         bright_ff     <= 16'd10000;
         sat_ff        <= 16'd55000;
         weak_ff       <= 16'd20000;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         level_ff      <= level_in;
         cool_ff       <= cool_in;
         mreq_ff.start <= mreq_in.start;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN:   gain_ff   <= csr_wdata;
               CSR_DARK:   dark_ff   <= csr_wdata[15:0];
               CSR_BRIGHT: bright_ff <= csr_wdata[15:0];
               CSR_SAT:    sat_ff    <= csr_wdata[15:0];
               CSR_WEAK:   weak_ff   <= csr_wdata[15:0];
               default:    ;
            endcase
         end
      end
   end

   level_in_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= 3'd4) else $error("level out of range");
   lux_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.lux <= LUX_MAX) else $error("lux above limit");
   no_lux_on_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.lux_valid |-> rsp_payload.lux == 18'd0)
      else $error("lux on a non-measurement item");
   step_excl_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.lux_valid && rsp_payload.reconfigure))
      else $error("reconfigure together with lux");
   step_loads_cool: assert property (@(posedge clock) disable iff (reset)
      req_take && moved && !req_payload.read_failed |=> cool_ff == 2'(COOLDOWN_SAMPLES))
      else $error("cooldown not loaded on step");

endmodule

FILE: sim/lsal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsal_checker: result predictor and scoreboard for the auto-ranging lux block
// Follows register writes and accepted items, predicts each result item and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module lsal_checker
   import lsal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_payload,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   localparam int HOLD_SAMPLES = 2;
   localparam logic [33:0] LEVEL_RES [5] = '{34'd18038863, 34'd1154487209,
      34'd2308974418, 34'd4617948837, 34'd9235897673};
   localparam logic [9:0] LEVEL_MS [5] = '{10'd800, 10'd100, 10'd100, 10'd50, 10'd25};

   logic [23:0] gain;
   logic [15:0] dark_th, bright_th, sat_th, weak_th;
   logic [2:0]  cur_level;
   logic [1:0]  hold_left;
   rsp_type     expected_results[$];

   function automatic logic [17:0] lux_of(logic [15:0] raw, logic [2:0] lvl);
      logic signed [127:0] x, h, p, v;
      x = raw * LEVEL_RES[lvl];
      if (lvl == 3'd0) begin
         p = x;
      end else begin
         h = ((COEF_A * x) >>> 32) + COEF_B;
         h = ((h * x) >>> 40) + COEF_C;
         h = ((h * x) >>> 64) + COEF_D;
         p = (h * x) >>> 32;
      end
      if (p <= 0) return '0;
      v = (p * $signed({104'd0, gain}) + (128'sd1 <<< 47)) >>> 48;
      return (v > 128'sd140000) ? LUX_MAX : v[17:0];
   endfunction

   function automatic rsp_type next_result(req_type r);
      rsp_type     o;
      logic [2:0]  nxt;
      logic        moved;
      nxt   = cur_level;
      moved = 1'b0;
      o     = '0;
      if (!r.read_failed) begin
         if (hold_left != 0) begin
            hold_left = hold_left - 2'd1;
         end else begin
            case (cur_level)
               3'd0: if (r.raw_count > sat_th || r.raw_count > weak_th) nxt = 3'd1;
               3'd1: begin
                  if (r.raw_count > sat_th) nxt = 3'd2;
                  else if (r.raw_count <= dark_th) nxt = 3'd0;
               end
               3'd2, 3'd3: begin
                  if (r.raw_count > bright_th) nxt = cur_level + 3'd1;
                  else if (r.raw_count <= dark_th) nxt = cur_level - 3'd1;
               end
               default: if (r.raw_count <= dark_th) nxt = 3'd3;
            endcase
            moved = nxt != cur_level;
         end
         if (moved) begin
            cur_level = nxt;
            hold_left = 2'(HOLD_SAMPLES);
         end else begin
            o.lux = lux_of(r.raw_count, nxt);
         end
      end
      o.lux_valid      = !r.read_failed && !moved;
      o.reconfigure    = moved;
      o.level          = nxt;
      o.integration_ms = LEVEL_MS[nxt];
      o.read_error     = r.read_failed;
      return o;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         gain      = 24'd65536;
         dark_th   = 16'd100;
         bright_th = 16'd10000;
         sat_th    = 16'd55000;
         weak_th   = 16'd20000;
         cur_level = 3'd2;
         hold_left = 2'd0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GAIN:   gain      = csr_wdata;
               CSR_DARK:   dark_th   = csr_wdata[15:0];
               CSR_BRIGHT: bright_th = csr_wdata[15:0];
               CSR_SAT:    sat_th    = csr_wdata[15:0];
               CSR_WEAK:   weak_th   = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_results.size() == 0) begin
               $display("%0t result item with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.lux != want.lux) report("lux", rsp_payload.lux, want.lux);
               if (rsp_payload.lux_valid != want.lux_valid)
                  report("lux_valid", rsp_payload.lux_valid, want.lux_valid);
               if (rsp_payload.reconfigure != want.reconfigure)
                  report("reconfigure", rsp_payload.reconfigure, want.reconfigure);
               if (rsp_payload.level != want.level)
                  report("level", rsp_payload.level, want.level);
               if (rsp_payload.integration_ms != want.integration_ms)
                  report("integration_ms", rsp_payload.integration_ms, want.integration_ms);
               if (rsp_payload.read_error != want.read_error)
                  report("read_error", rsp_payload.read_error, want.read_error);
            end
         end
         if (req_valid && !req_stall) expected_results.push_back(next_result(req_payload));
      end
      pending = expected_results.size();
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the auto-ranging lux block
// Drives sample items and register writes across several threshold and gain
// settings, with bursty input and a stalling receiver; a checker module
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
   import lsal_pkg::*;

   localparam int IDLE_LIMIT = 5000;   // cycles with no transfer of any kind
   localparam int LONG_HOLD  = 700;    // well over one full conversion

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   int fail_count, pending, checked;
   int sent       = 0;
   int idle_count = 0;
   int hold_asks  = 0;   // bumped by the stimulus to ask for a long receiver hold
   int burst_left = 0;

   always #5 clock = ~clock;

   light_sensor_autorange_lux_top dut (.*);

   lsal_checker u_checker (.*);

   // watchdog: nothing accepted for too long means the block has hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("timeout: no transfer in %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // receiver: stall pattern redrawn whenever the mode age counter wraps, plus one long hold on request
   int hold_seen = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_age = 0;
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_seen) begin
         hold_seen <= hold_asks;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_age == 0) stall_mode <= $urandom_range(0, 3);
         mode_age <= (mode_age + 1) % 64;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;                       // free running stretch
            1:       rsp_stall <= ($urandom_range(0, 9) < 3);
            2:       rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= ($urandom_range(0, 39) == 0);
         endcase
      end
   end

   // one sample item, with burst gaps before it
   task automatic send_item(logic [15:0] raw, logic failed);
      @(negedge clock);   // the previous item's valid drop has settled
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= '{raw_count: raw, read_failed: failed};
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // register write, only called with the block drained
   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);   // the previous write's valid drop has settled
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_thresholds(logic [15:0] dk, logic [15:0] br, logic [15:0] st,
                                 logic [15:0] wk);
      write_reg(CSR_DARK, dk);
      write_reg(CSR_BRIGHT, br);
      write_reg(CSR_SAT, st);
      write_reg(CSR_WEAK, wk);
   endtask

   // random raw counts, weighted towards the thresholds so the level walks around
   function automatic logic [15:0] pick_raw();
      case ($urandom_range(0, 6))
         0:       return 16'($urandom_range(0, 150));
         1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         2:       return 16'($urandom_range(0, 65535));
         3:       return 16'($urandom_range(9900, 10100));
         4:       return 16'($urandom_range(19900, 20100));
         5:       return 16'($urandom_range(54900, 55100));
         default: return 16'($urandom_range(200, 9000));
      endcase
   endfunction

   task automatic random_items(int n);
      for (int i = 0; i < n; i++) begin
         send_item(pick_raw(), $urandom_range(0, 9) == 0);
         if (i == n / 2 && $urandom_range(0, 1)) drain();   // sender waits for results
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: defaults, extremes, read errors, steps in both directions
      send_item(16'd0, 1'b1);          // read error keeps level 2
      send_item(16'hFFFF, 1'b1);
      send_item(16'd5000, 1'b0);       // plain conversion at level 2
      send_item(16'hFFFF, 1'b0);       // step up to 3, cooldown starts
      send_item(16'hFFFF, 1'b0);       // cooldown
      send_item(16'd0, 1'b1);          // error does not count the cooldown down
      send_item(16'hFFFF, 1'b0);
      send_item(16'hFFFF, 1'b0);       // step up to 4
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'hFFFF, 1'b0);       // saturated lux at level 4
      send_item(16'd100, 1'b0);        // dark boundary: step down to 3
      send_item(16'd101, 1'b0);
      send_item(16'd101, 1'b0);
      send_item(16'd50, 1'b0);         // down to 2
      send_item(16'd1, 1'b0);
      send_item(16'd1, 1'b0);
      send_item(16'd0, 1'b0);          // down to 1
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);
      send_item(16'd0, 1'b0);          // down to 0
      send_item(16'd3, 1'b0);
      send_item(16'd3, 1'b0);
      send_item(16'd20001, 1'b0);      // weak exit back to level 1
      send_item(16'd55001, 1'b0);
      drain();

      // default thresholds, with the long receiver hold while items keep coming
      write_reg(CSR_GAIN, 24'd65536);
      set_thresholds(16'd100, 16'd10000, 16'd55000, 16'd20000);
      hold_asks++;
      random_items(220);
      drain();

      // zero gain, crossed thresholds so the upward test must win
      write_reg(CSR_GAIN, 24'd0);
      set_thresholds(16'd30000, 16'd10000, 16'd20000, 16'd25000);
      random_items(200);
      drain();

      // largest gain pushes most results into the clamp
      write_reg(CSR_GAIN, 24'hFFFFFF);
      set_thresholds(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_items(200);
      drain();

      // out-of-range register indexes must be ignored
      write_reg(3'd5, 24'h123456);
      write_reg(3'd7, 24'hFFFFFF);
      write_reg(CSR_GAIN, 24'($urandom_range(0, 24'hFFFFFF)));
      set_thresholds(16'hFFFF, 16'd0, 16'd0, 16'd0);
      random_items(200);
      drain();

      // random mid settings, gain around unity
      write_reg(CSR_GAIN, 24'($urandom_range(40000, 200000)));
      set_thresholds(16'($urandom_range(0, 400)), 16'($urandom_range(5000, 15000)),
                     16'($urandom_range(50000, 60000)), 16'($urandom_range(15000, 25000)));
      hold_asks++;
      random_items(220);
      drain();

      write_reg(CSR_GAIN, 24'd65536);
      set_thresholds(16'd100, 16'd10000, 16'd55000, 16'd20000);
      random_items(220);

      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("sent %0d sample items over six register settings; %0d results checked",
               sent, checked);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
